### src/hdit_pkg.sv
// ----------------------------------------------------------------------------
// hdit_pkg
// Shared types, constants and helpers for the HID descriptor item tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package hdit_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TagW   = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 9;

  // Six-bit prefix tag that opens a long item.
  localparam logic [5:0] LongTag = 6'h3F;

  // Item type code in the two low tag bits that marks a global item.
  localparam logic [1:0] TypeGlobal = 2'b01;

  // Size code that stands for four data bytes.
  localparam logic [1:0] SizeFour = 2'b11;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [ValueW-1:0] value;
    logic              is_long;
  } token_t;

  // Sign-extends one- and two-byte global item data to the full word.
  function automatic logic [ValueW-1:0] sign_fix(
    input logic [TagW-1:0]   tag,
    input logic [CountW-1:0] size,
    input logic [ValueW-1:0] value
  );
    logic [ValueW-1:0] res;
    res = value;
    if (tag[1:0] == TypeGlobal) begin
      if (size == CountW'(1) && value[7]) begin
        res = {{(ValueW-8){1'b1}}, value[7:0]};
      end else if (size == CountW'(2) && value[15]) begin
        res = {{(ValueW-16){1'b1}}, value[15:0]};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/hdit_core.sv
// ----------------------------------------------------------------------------
// hdit_core
// Item parsing state and the per-byte update that produces completed tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module hdit_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [hdit_pkg::ByteW-1:0] desc_byte,
  input  wire logic                      last_byte,
  output logic                           emit,
  output hdit_pkg::token_t               token
);
  import hdit_pkg::*;

  logic              in_item_r,  in_item_nxt;
  logic [CountW-1:0] needed_r,   needed_nxt;
  logic [CountW-1:0] index_r,    index_nxt;
  logic [TagW-1:0]   tag_r,      tag_nxt;
  logic [ValueW-1:0] value_r,    value_nxt;
  logic              long_r,     long_nxt;

  always_comb begin
    in_item_nxt = in_item_r;
    needed_nxt  = needed_r;
    index_nxt   = index_r;
    tag_nxt     = tag_r;
    value_nxt   = value_r;
    long_nxt    = long_r;
    emit        = 1'b0;

    if (!in_item_r) begin
      // Prefix byte: tag in bits 7:2, size code in bits 1:0.
      tag_nxt    = {{(TagW-6){1'b0}}, desc_byte[7:2]};
      long_nxt   = (desc_byte[7:2] == LongTag);
      needed_nxt = (desc_byte[1:0] == SizeFour) ? CountW'(4)
                                                : {{(CountW-2){1'b0}}, desc_byte[1:0]};
      index_nxt  = '0;
      value_nxt  = '0;
      if (needed_nxt == '0) begin
        emit = 1'b1;
      end else begin
        in_item_nxt = 1'b1;
      end
    end else begin
      if (long_r) begin
        // Long item: length byte, then the long tag, then skipped data.
        if (index_r == '0) begin
          needed_nxt = needed_r + {{(CountW-ByteW){1'b0}}, desc_byte};
        end else if (index_r == CountW'(1)) begin
          tag_nxt = {desc_byte, tag_r[7:0]};
        end
      end else begin
        unique case (index_r[1:0])
          2'd0:    value_nxt = value_r | {24'h0, desc_byte};
          2'd1:    value_nxt = value_r | {16'h0, desc_byte, 8'h0};
          2'd2:    value_nxt = value_r | {8'h0, desc_byte, 16'h0};
          default: value_nxt = value_r | {desc_byte, 24'h0};
        endcase
      end
      index_nxt = index_r + CountW'(1);
      if (index_nxt == needed_nxt) begin
        in_item_nxt = 1'b0;
        emit        = 1'b1;
      end
    end

    token.tag     = tag_nxt;
    token.value   = sign_fix(tag_nxt, needed_nxt, value_nxt);
    token.is_long = long_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      in_item_r <= 1'b0;
      needed_r  <= '0;
      index_r   <= '0;
      tag_r     <= '0;
      value_r   <= '0;
      long_r    <= 1'b0;
    end else if (accept) begin
      in_item_r <= in_item_nxt;
      needed_r  <= needed_nxt;
      index_r   <= index_nxt;
      tag_r     <= tag_nxt;
      value_r   <= value_nxt;
      long_r    <= long_nxt;
    end
  end

endmodule

`default_nettype wire

### src/hdit_out_buf.sv
// ----------------------------------------------------------------------------
// hdit_out_buf
// Two-entry output stage: a result register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module hdit_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire hdit_pkg::token_t push_token,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hdit_pkg::token_t      out_token
);
  import hdit_pkg::*;

  logic   main_valid_r;
  logic   skid_valid_r;
  token_t main_r;
  token_t skid_r;

  // The skid entry only fills while the result register is stalled.
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_token = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        skid_r <= push_token;
      end else begin
        main_r <= push_token;
      end
    end else if (push) begin
      skid_r <= push_token;
    end
  end

endmodule

`default_nettype wire

### src/hid_descriptor_item_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// hid_descriptor_item_tokenizer_unit
// Splits a HID report descriptor byte stream into one token per item.
// ----------------------------------------------------------------------------
// The unit takes one descriptor byte per beat and returns one token for every
// item that the byte completes. A short item is tokenized from its prefix byte
// (tag and type in bits 7:2, size code in bits 1:0 meaning 0, 1, 2 or 4 data
// bytes) and its little-endian data; global items with one or two data bytes
// come out sign-extended to 32 bits, and a size of zero completes on the prefix
// with a value of zero. A prefix tag of all ones opens a long item: its first
// data byte adds to the length, its second gives bits 15:8 of the tag, and the
// rest of its data is skipped, so a long item always reports a value of zero.
// A beat with tlast set is parsed as usual and then returns the parser to its
// reset state, dropping any item still open. A completed token goes to the
// result register, or to the skid entry while that register is stalled, so one
// byte per cycle is sustained while the consumer keeps up. The only stall comes
// from the output: a result register plus one skid entry absorb a stalled
// consumer, and the input deasserts in_tready only while both hold a token.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_descriptor_item_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] desc_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] item_tag, [47:16] item_value
  output logic             out_tuser   // item_long
);
  import hdit_pkg::*;

  logic   accept;
  logic   emit;
  logic   space;
  token_t token;
  token_t out_token;

  // A byte is taken whenever the output stage can hold one more token.
  assign in_tready = space;
  assign accept    = in_tvalid && in_tready;

  hdit_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .desc_byte (in_tdata),
    .last_byte (in_tlast),
    .emit      (emit),
    .token     (token)
  );

  hdit_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && emit),
    .push_token (token),
    .space      (space),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_token  (out_token)
  );

  assign out_tdata = {out_token.value, out_token.tag};
  assign out_tuser = out_token.is_long;

endmodule

`default_nettype wire

### tb/sv/tb_hid_descriptor_item_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// tb_hid_descriptor_item_tokenizer_unit
// Self-checking testbench for the HID descriptor item tokenizer.
// ----------------------------------------------------------------------------
// Descriptor bytes are streamed into the unit one beat at a time. Each beat is
// run through a behavioral tokenizer held in a small scoreboard class, and
// every token the unit emits is compared field by field with the oldest token
// that the behavioral tokenizer queued. A short directed sequence covers the
// item forms of interest; the random part is mostly well-formed descriptors
// with random item content, plus truncated descriptors and raw noise. Both
// sides of the stream idle at random, the consumer is held off long enough to
// back up the input, and a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
`default_nettype none

// Behavioral tokenizer plus the queue of tokens it predicts.
class token_scoreboard;
  hdit_pkg::token_t expected_tokens[$];

  // Parser state kept by the behavioral tokenizer.
  bit          item_open;
  bit          item_is_long;
  logic [8:0]  bytes_needed;
  logic [8:0]  byte_count;
  logic [15:0] tag_acc;
  logic [31:0] value_acc;

  int errors;
  int tokens_checked;
  int long_tokens;

  function new();
    errors         = 0;
    tokens_checked = 0;
    long_tokens    = 0;
    clear_parser();
  endfunction

  function void clear_parser();
    item_open    = 1'b0;
    item_is_long = 1'b0;
    bytes_needed = '0;
    byte_count   = '0;
    tag_acc      = '0;
    value_acc    = '0;
  endfunction

  function void flag_mismatch(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] token mismatch: %s", $realtime, msg);
    end
  endfunction

  // Advances the behavioral tokenizer by one accepted descriptor byte and
  // queues the token that the byte completes, if any.
  function void tokenize_byte(input logic [7:0] b, input logic last);
    bit               done;
    hdit_pkg::token_t tok;
    done = 1'b0;
    if (!item_open) begin
      tag_acc      = {10'd0, b[7:2]};
      item_is_long = (b[7:2] == hdit_pkg::LongTag);
      bytes_needed = (b[1:0] == hdit_pkg::SizeFour) ? 9'd4 : {7'd0, b[1:0]};
      byte_count   = '0;
      value_acc    = '0;
      if (bytes_needed == 9'd0) begin
        done = 1'b1;
      end else begin
        item_open = 1'b1;
      end
    end else begin
      if (item_is_long) begin
        if (byte_count == 9'd0) begin
          bytes_needed = bytes_needed + {1'b0, b};
        end else if (byte_count == 9'd1) begin
          tag_acc[15:8] = tag_acc[15:8] | b;
        end
      end else begin
        value_acc = value_acc | (32'(b) << (8 * byte_count[1:0]));
      end
      byte_count = byte_count + 9'd1;
      if (byte_count == bytes_needed) begin
        item_open = 1'b0;
        done      = 1'b1;
      end
    end
    if (done) begin
      tok.tag     = tag_acc;
      tok.value   = value_acc;
      tok.is_long = item_is_long;
      if (tag_acc[1:0] == hdit_pkg::TypeGlobal) begin
        if (bytes_needed == 9'd1 && value_acc[7]) begin
          tok.value = value_acc | 32'hFFFF_FF00;
        end else if (bytes_needed == 9'd2 && value_acc[15]) begin
          tok.value = value_acc | 32'hFFFF_0000;
        end
      end
      expected_tokens.push_back(tok);
    end
    if (last) begin
      clear_parser();
    end
  endfunction

  // Compares one emitted token with the oldest queued prediction.
  function void match_token(input logic [15:0] tag, input logic [31:0] value,
                            input logic is_long);
    hdit_pkg::token_t exp_tok;
    if (expected_tokens.size() == 0) begin
      flag_mismatch($sformatf("unexpected token tag %h value %h long %b",
                              tag, value, is_long));
      return;
    end
    exp_tok = expected_tokens.pop_front();
    tokens_checked++;
    if (is_long === 1'b1) begin
      long_tokens++;
    end
    if (tag !== exp_tok.tag) begin
      flag_mismatch($sformatf("item_tag expected %h, got %h", exp_tok.tag, tag));
    end
    if (value !== exp_tok.value) begin
      flag_mismatch($sformatf("item_value expected %h, got %h", exp_tok.value, value));
    end
    if (is_long !== exp_tok.is_long) begin
      flag_mismatch($sformatf("item_long expected %b, got %b", exp_tok.is_long, is_long));
    end
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction
endclass

module tb_hid_descriptor_item_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles the consumer is held off during the back-pressure stretch.
  localparam int HoldCycles = 400;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int StallLimit = 5000;
  // Random beats per idling phase.
  localparam int PhaseBeats = 650;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  token_scoreboard sb = new();

  // Idle percentages for the producer and consumer sides.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Request from the main sequence for a long consumer hold-off.
  bit hold_req    = 1'b0;
  int hold_left   = 0;

  int beats_sent  = 0;
  int descriptors = 0;
  int stall_cycles = 0;

  hid_descriptor_item_tokenizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Consumer side. A pending hold-off request turns into a countdown that
  // keeps out_tready low; otherwise the ready is randomized per cycle.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor. Tokens come out of a register loaded by the beat that
  // completes them, so the prediction is always queued before the check.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.match_token(out_tdata[15:0], out_tdata[47:16], out_tuser);
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("hid_descriptor_item_tokenizer_unit regression: fail");
        $finish;
      end
    end
  end

  // Offers one descriptor byte, with a random idle gap first, and returns
  // at the edge where the beat is accepted. The byte goes to the predictor
  // at that same edge.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.tokenize_byte(b, last);
    beats_sent++;
  endtask

  // Drops tvalid so the last beat is not offered twice.
  task automatic park();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the producer until every predicted token has come out.
  task automatic wait_drained();
    park();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Appends one random item. Most are short items with any tag except the
  // long-item escape; about one in eight is a long item, usually with a few
  // data bytes and now and then with a length byte anywhere up to 255.
  task automatic add_item(ref logic [7:0] q[$]);
    logic [1:0] code;
    logic [5:0] tag6;
    int         n_data;
    int         len;
    code   = 2'($urandom_range(0, 3));
    n_data = (code == hdit_pkg::SizeFour) ? 4 : int'(code);
    if ($urandom_range(99) < 12) begin
      q.push_back({hdit_pkg::LongTag, code});
      if (n_data > 0) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        q.push_back(8'(len));
        repeat (n_data + len - 1) q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      tag6 = 6'($urandom_range(0, 62));
      q.push_back({tag6, code});
      repeat (n_data) q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Sends one random descriptor terminated by tlast: mostly well-formed,
  // some cut short in the middle of an item, some pure noise.
  task automatic send_descriptor();
    logic [7:0] bytes[$];
    int         kind;
    int         n_items;
    int         cut;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 20)) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_items = $urandom_range(1, 10);
      repeat (n_items) add_item(bytes);
      if (kind < 25) begin
        cut = $urandom_range(1, bytes.size());
        while (bytes.size() > cut) void'(bytes.pop_back());
      end
    end
    foreach (bytes[i]) begin
      send_beat(bytes[i], i == bytes.size() - 1);
    end
    descriptors++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 84;

    // Directed items. A size-zero main item and a size-zero long item both
    // complete on their prefix.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFC, 1'b0);
    // One-byte global item, negative and positive: sign extension.
    send_beat(8'h15, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h15, 1'b0);
    send_beat(8'h7F, 1'b0);
    // Two-byte global item with the sign bit set.
    send_beat(8'h16, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    // Four-byte global item: little-endian, never extended.
    send_beat(8'h27, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h03, 1'b0);
    send_beat(8'h84, 1'b0);
    // One-byte main item with the top bit set is not extended.
    send_beat(8'h81, 1'b0);
    send_beat(8'hFF, 1'b0);
    // Long item with two data bytes that are skipped.
    send_beat(8'hFE, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b0);
    // Long item whose length ends before its tag byte.
    send_beat(8'hFD, 1'b0);
    send_beat(8'h00, 1'b0);
    // Descriptor ending inside an item: the item is dropped.
    send_beat(8'h26, 1'b0);
    send_beat(8'h11, 1'b1);
    // A lone prefix carrying tlast, then a size-zero item carrying tlast.
    send_beat(8'hFF, 1'b1);
    send_beat(8'hF8, 1'b1);
    wait_drained();

    // Random descriptors in three idling phases. The producer waits for the
    // output to drain between phases; the last phase runs with no idling and
    // opens with a long consumer hold-off so the input backs up.
    beats_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      while (beats_sent < (phase + 1) * PhaseBeats) begin
        send_descriptor();
      end
      wait_drained();
    end

    // Let any stray token surface before the verdict.
    repeat (16) @(posedge clk);

    $display("Covered %0d random descriptors (%0d random bytes) after the directed items.",
             descriptors, beats_sent);
    $display("Checked %0d tokens, %0d of them long items; %0d mismatches.",
             sb.tokens_checked, sb.long_tokens, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hid_descriptor_item_tokenizer_unit regression: pass");
    end else begin
      $display("hid_descriptor_item_tokenizer_unit regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
